// ===== sv/xml_text_escaper_macros.svh =====
// assertion macros shared by the checker of the xml text escaper
// no dependencies; included by files that hold concurrent assertions
`ifndef XML_TEXT_ESCAPER_MACROS_SVH
`define XML_TEXT_ESCAPER_MACROS_SVH

// antecedent holds, consequent must hold in the same cycle
`define XTE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// antecedent holds, consequent must hold in the next cycle
`define XTE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/xte_pkg.sv =====
// shared types, constants and escape tables of the xml text escaper
// no dependencies; used by the cell, emitter and top level
`timescale 1ns / 1ps

package xte_pkg;

  localparam int WindowDepth = 6;
  localparam int SeqIdxW     = 3;

  typedef enum logic [2:0] {
    ESC_PLAIN,
    ESC_LT,
    ESC_GT,
    ESC_AMP,
    ESC_QUOT,
    ESC_APOS
  } esc_t;

  // control broadcast to every window cell
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  // handoff of one window byte to the emitter
  typedef struct packed {
    logic       load;
    esc_t       code;
    logic [7:0] ch;
    logic       last;
  } emit_req_t;

  // entity spellings, first character in the lowest byte
  localparam logic [5:0][7:0] EntLt   = {8'h00, 8'h00, ";", "t", "l", "&"};
  localparam logic [5:0][7:0] EntGt   = {8'h00, 8'h00, ";", "t", "g", "&"};
  localparam logic [5:0][7:0] EntAmp  = {8'h00, ";", "p", "m", "a", "&"};
  localparam logic [5:0][7:0] EntQuot = {";", "t", "o", "u", "q", "&"};
  localparam logic [5:0][7:0] EntApos = {";", "s", "o", "p", "a", "&"};

  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "A" && c <= "Z") begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // compare the first n bytes of the window against an entity
  function automatic logic spells(input logic [WindowDepth-1:0][7:0] w,
                                  input logic [WindowDepth-1:0] vld,
                                  input logic [5:0][7:0] ent,
                                  input logic [SeqIdxW-1:0] n);
    logic ok;
    ok = vld[n-1];
    for (int k = 0; k < WindowDepth; k++) begin
      if (k < int'(n) && fold(w[k]) != ent[k]) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // pick the output sequence for the head byte of the window
  function automatic esc_t classify(input logic [WindowDepth-1:0][7:0] w,
                                    input logic [WindowDepth-1:0] vld);
    esc_t r;
    r = ESC_PLAIN;
    unique case (w[0])
      "<":  r = ESC_LT;
      ">":  r = ESC_GT;
      "\"": r = ESC_QUOT;
      "'":  r = ESC_APOS;
      "&": begin
        if (spells(w, vld, EntLt, 3'd4) || spells(w, vld, EntGt, 3'd4) ||
            spells(w, vld, EntAmp, 3'd5) || spells(w, vld, EntQuot, 3'd6) ||
            spells(w, vld, EntApos, 3'd6)) begin
          r = ESC_PLAIN;
        end else begin
          r = ESC_AMP;
        end
      end
      default: r = ESC_PLAIN;
    endcase
    return r;
  endfunction

  function automatic logic [SeqIdxW-1:0] seq_last_idx(input esc_t code);
    logic [SeqIdxW-1:0] r;
    unique case (code)
      ESC_PLAIN: r = 3'd0;
      ESC_LT:    r = 3'd3;
      ESC_GT:    r = 3'd3;
      ESC_AMP:   r = 3'd4;
      ESC_QUOT:  r = 3'd5;
      ESC_APOS:  r = 3'd5;
      default:   r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] seq_byte(input esc_t code,
                                          input logic [SeqIdxW-1:0] idx,
                                          input logic [7:0] ch);
    logic [7:0] r;
    unique case (code)
      ESC_PLAIN: r = ch;
      ESC_LT:    r = EntLt[idx];
      ESC_GT:    r = EntGt[idx];
      ESC_AMP:   r = EntAmp[idx];
      ESC_QUOT:  r = EntQuot[idx];
      ESC_APOS:  r = EntApos[idx];
      default:   r = ch;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/xte_cell.sv =====
// one lookahead window cell: holds a byte and its valid bit
// depends on xte_pkg; chained by xml_text_escaper, oldest byte in cell 0
`timescale 1ns / 1ps

module xte_cell (
  input  logic              clk,
  input  logic              rst,
  input  xte_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]        in_data,
  input  logic [7:0]        next_data,
  input  logic              next_vld,
  input  logic              prev_vld,
  output logic [7:0]        data,
  output logic              vld
);
  import xte_pkg::*;

  logic [7:0] data_next;
  logic       vld_next;

  always_comb begin
    data_next = data;
    vld_next  = vld;
    priority if (ctrl.shift) begin
      if (next_vld) begin
        vld_next  = 1'b1;
        data_next = next_data;
      end else if (ctrl.load && vld) begin
        // tail cell frees up and takes the new item at once
        vld_next  = 1'b1;
        data_next = in_data;
      end else begin
        vld_next = 1'b0;
      end
    end else if (!vld && ctrl.load && prev_vld) begin
      vld_next  = 1'b1;
      data_next = in_data;
    end else begin
      data_next = data;
      vld_next  = vld;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= vld_next;
    end
    data <= data_next;
  end

endmodule

// ===== sv/xte_emit.sv =====
// expands one window byte into its output sequence, one byte per cycle while the output is ready
// depends on xte_pkg; drives the master side of xml_text_escaper
`timescale 1ns / 1ps

module xte_emit (
  input  logic               clk,
  input  logic               rst,
  input  xte_pkg::emit_req_t req,
  output logic               free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_data,
  output logic               out_last
);
  import xte_pkg::*;

  logic               busy, busy_next;
  esc_t               code, code_next;
  logic [7:0]         ch, ch_next;
  logic [SeqIdxW-1:0] idx, idx_next;
  logic               last_flag, last_next;
  logic               at_end;

  always_comb begin
    at_end    = idx == seq_last_idx(code);
    free      = !busy || (out_ready && at_end);
    busy_next = busy;
    code_next = code;
    ch_next   = ch;
    idx_next  = idx;
    last_next = last_flag;
    if (busy && out_ready && !at_end) begin
      idx_next = idx + 3'd1;
    end else if (free) begin
      busy_next = req.load;
      if (req.load) begin
        code_next = req.code;
        ch_next   = req.ch;
        last_next = req.last;
        idx_next  = '0;
      end
    end
  end

  assign out_valid = busy;
  assign out_data  = seq_byte(code, idx, ch);
  assign out_last  = last_flag && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else begin
      busy <= busy_next;
      idx  <= idx_next;
    end
    code      <= code_next;
    ch        <= ch_next;
    last_flag <= last_next;
  end

endmodule

// ===== sv/xml_text_escaper.sv =====
// Escapes a byte stream for use as XML text, one byte per item. Bytes pass
// through a six-byte lookahead window, so the first output appears only once
// six bytes are held or the last item of a string has arrived. Plain text
// moves at one item per cycle while the output is ready. A byte that becomes
// &lt; &gt; &amp; &quot; or &apos; occupies the output until its whole entity
// is sent, and while the window is full the input waits for it. An '&' that
// already starts one of these entities (letters in any case, all of it inside
// the window) is passed unchanged. After an item with tlast the window drains,
// each held byte expanded in turn, and no input is taken until the final held
// byte has moved to the output stage.
// depends on xte_pkg, xte_cell and xte_emit
`timescale 1ns / 1ps

module xml_text_escaper (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast
);
  import xte_pkg::*;

  logic [WindowDepth-1:0][7:0] cell_data;
  logic [WindowDepth-1:0]      cell_vld;
  cell_ctrl_t                  ctrl;
  emit_req_t                   req;
  logic                        emit_free;
  logic                        draining, draining_next;
  logic                        pop, accept;

  // head leaves when the emitter is free and the window is full or a drain is on
  assign pop    = emit_free && cell_vld[0] && (draining || cell_vld[WindowDepth-1]);
  assign s_axis_tready = !draining && (!cell_vld[WindowDepth-1] || pop);
  assign accept = s_axis_tvalid && s_axis_tready;

  assign ctrl.shift = pop;
  assign ctrl.load  = accept;

  assign req.load = pop;
  assign req.code = classify(cell_data, cell_vld);
  assign req.ch   = cell_data[0];
  assign req.last = draining && !cell_vld[1];

  always_comb begin
    priority if (accept && s_axis_tlast) begin
      draining_next = 1'b1;
    end else if (pop && req.last) begin
      draining_next = 1'b0;
    end else begin
      draining_next = draining;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
    end else begin
      draining <= draining_next;
    end
  end

  for (genvar i = 0; i < WindowDepth; i++) begin : g_cell
    logic [7:0] nb_data;
    logic       nb_vld;
    logic       pv_vld;

    if (i == WindowDepth - 1) begin : g_tail
      assign nb_data = 8'h00;
      assign nb_vld  = 1'b0;
    end else begin : g_mid
      assign nb_data = cell_data[i+1];
      assign nb_vld  = cell_vld[i+1];
    end

    if (i == 0) begin : g_head
      assign pv_vld = 1'b1;
    end else begin : g_rest
      assign pv_vld = cell_vld[i-1];
    end

    xte_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .in_data   (s_axis_tdata),
      .next_data (nb_data),
      .next_vld  (nb_vld),
      .prev_vld  (pv_vld),
      .data      (cell_data[i]),
      .vld       (cell_vld[i])
    );
  end

  xte_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .free      (emit_free),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

// ===== sv/xte_checker.sv =====
// port-level checks for the xml text escaper, bound to the top level
// depends on xml_text_escaper_macros.svh
`timescale 1ns / 1ps

`include "xml_text_escaper_macros.svh"

module xte_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  // a stalled output item holds
  `XTE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output item changed while stalled")

  // escaped text never carries a raw <, >, double quote or apostrophe
  `XTE_ASSERT_NOW(a_no_raw, m_axis_tvalid, m_axis_tdata != "<" && m_axis_tdata != ">" && m_axis_tdata != "\"" && m_axis_tdata != "'", "unescaped markup character on output")

  // the end of a string starts a drain that holds off input
  `XTE_ASSERT_NEXT(a_drain_hold, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready, "input taken right after the last item")

endmodule

bind xml_text_escaper xte_checker u_xte_checker (.*);
